[rtl/topc_pkg.sv]
// topc_pkg: shared types and codes for the timed output pulse controller
// used by topc_alu and timed_output_pulse_controller_unit
`timescale 1ns / 1ps

package topc_pkg;

    typedef enum logic [3:0] {
        MODE_SET     = 4'd0,
        MODE_CLEAR   = 4'd1,
        MODE_TOGGLE  = 4'd2,
        MODE_PULSE   = 4'd3,
        MODE_DSET    = 4'd4,
        MODE_DCLEAR  = 4'd5,
        MODE_DTOGGLE = 4'd6,
        MODE_DPULSE  = 4'd7,
        MODE_TICK    = 4'd8
    } t_mode;

    typedef enum logic [2:0] {
        ACT_IDLE    = 3'd0,
        ACT_PULSE   = 3'd1,
        ACT_DSET    = 3'd2,
        ACT_DCLEAR  = 3'd3,
        ACT_DTOGGLE = 3'd4,
        ACT_DPULSE  = 3'd5
    } t_act;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_TICK,
        ST_SWEEP,
        ST_CMD,
        ST_CMD2,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic [31:0] a;
        logic [31:0] b;
        logic        sub;
    } t_alu_req;

    localparam int unsigned REG_MIN_PULSE = 0;
    localparam int unsigned REG_MIN_DELAY = 1;

endpackage

[rtl/topc_alu.sv]
// topc_alu: shared 32-bit add/subtract unit with the wrapping deadline test
// depends on topc_pkg
`timescale 1ns / 1ps

module topc_alu (
    input  topc_pkg::t_alu_req i_req,
    output logic [31:0]        o_sum,
    output logic               o_passed
);

    logic [31:0] w_b;

    assign w_b      = i_req.sub ? ~i_req.b : i_req.b;
    assign o_sum    = i_req.a + w_b + {31'd0, i_req.sub};
    // deadline minus now is zero or negative
    assign o_passed = (o_sum == 32'd0) || o_sum[31];

endmodule

[rtl/timed_output_pulse_controller_unit.sv]
// timed_output_pulse_controller_unit: top level of the timed output pulse controller
// depends on topc_pkg and topc_alu
`timescale 1ns / 1ps

// Usage
// Commands enter on the s_axis channel, one word each; every command gives one
// result word on m_axis with the pin levels and the mask of notified pins.
// The user writes configuration (min_pulse_width at 0x0, min_delay at 0x4) through
// the APB port only while the block is idle (unenforced); pready is always high.
// The block handles one word at a time under a small sequencer; s_axis_tready
// is high only when no word is in progress.
// From accept to result valid, set, clear, toggle, pulse and the plain delayed
// commands pass through ST_CMD, delayed pulse through ST_CMD and ST_CMD2, an
// ignored command straight to ST_OUT, a tick through ST_TICK and ST_SWEEP.
// This sequencing is set by the single shared adder: a tick increments the time and
// then compares one channel deadline per cycle, a delayed pulse takes two sums.
// The next word is accepted no earlier than the cycle after the result is taken.
// Reset clears all pins, pending actions, the time counter and the result
// register, and loads both minimums with 1.
// When the receiver stalls, the result word holds on m_axis and no new command
// is accepted until it is taken.

module timed_output_pulse_controller_unit #(
    parameter int unsigned NUM_OUTPUTS = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [3:0] mode, [6:4] channel, [37:7] delay_time, [68:38] width_time, [71:69] zero
    input  logic [71:0] s_axis_tdata,

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [7:0] pin_levels, [15:8] changed_mask
    output logic [15:0] m_axis_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int unsigned IW = (NUM_OUTPUTS > 1) ? $clog2(NUM_OUTPUTS) : 1;

    topc_pkg::t_state r_state, n_state;

    logic [15:0]      r_min_pw;
    logic [15:0]      r_min_dly;

    topc_pkg::t_mode  r_mode;
    logic [IW-1:0]    r_idx;
    logic [30:0]      r_dly;
    logic [30:0]      r_wid;

    logic [31:0]      r_time;
    logic [NUM_OUTPUTS-1:0] r_pin;
    logic [NUM_OUTPUTS-1:0] r_mask;
    topc_pkg::t_act   r_act [NUM_OUTPUTS];
    logic [31:0]      r_dl  [NUM_OUTPUTS];
    logic [31:0]      r_dl2 [NUM_OUTPUTS];

    logic             w_accept;
    logic             w_cfg_wr;
    topc_pkg::t_mode  w_mode;
    logic [2:0]       w_ch;
    logic [30:0]      w_dly;
    logic [30:0]      w_wid;
    logic [30:0]      w_wid_c;
    logic [30:0]      w_dly_c;
    logic             w_ch_ok;

    logic             w_pin_rd;
    topc_pkg::t_act   w_act_rd;
    logic [31:0]      w_dl_rd;
    logic [31:0]      w_dl2_rd;

    topc_pkg::t_alu_req w_alu_req;
    logic [31:0]      w_sum;
    logic             w_passed;

    logic             w_pin_we;
    logic             w_pin_bit;
    logic             w_act_we;
    topc_pkg::t_act   w_act;
    logic             w_dl_we;
    logic [31:0]      w_dl;
    logic             w_dl2_we;
    logic             w_notify;
    logic             w_last;

    logic [31:0]      w_pin_ext;
    logic [31:0]      w_mask_ext;

    // input word fields
    assign w_mode  = topc_pkg::t_mode'(s_axis_tdata[3:0]);
    assign w_ch    = s_axis_tdata[6:4];
    assign w_dly   = s_axis_tdata[37:7];
    assign w_wid   = s_axis_tdata[68:38];
    assign w_wid_c = (w_wid < {15'd0, r_min_pw}) ? {15'd0, r_min_pw} : w_wid;
    assign w_dly_c = (w_dly < {15'd0, r_min_dly}) ? {15'd0, r_min_dly} : w_dly;
    assign w_ch_ok = (32'(w_ch) < NUM_OUTPUTS);

    assign s_axis_tready = (r_state == topc_pkg::ST_IDLE);
    assign w_accept      = s_axis_tvalid && s_axis_tready;

    assign w_pin_rd = r_pin[r_idx];
    assign w_act_rd = r_act[r_idx];
    assign w_dl_rd  = r_dl[r_idx];
    assign w_dl2_rd = r_dl2[r_idx];
    assign w_last   = (r_idx == IW'(NUM_OUTPUTS - 1));

    // configuration port
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_comb begin
        if (paddr[2] == 1'(topc_pkg::REG_MIN_DELAY)) begin
            prdata = {16'd0, r_min_dly};
        end else begin
            prdata = {16'd0, r_min_pw};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_pw  <= 16'd1;
            r_min_dly <= 16'd1;
        end else if (w_cfg_wr) begin
            if (paddr[2] == 1'(topc_pkg::REG_MIN_DELAY)) begin
                r_min_dly <= pwdata[15:0];
            end else begin
                r_min_pw <= pwdata[15:0];
            end
        end
    end

    topc_alu u_alu (
        .i_req    (w_alu_req),
        .o_sum    (w_sum),
        .o_passed (w_passed)
    );

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= topc_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_alu_req = '{a: r_time, b: 32'd1, sub: 1'b0};
        w_pin_we  = 1'b0;
        w_pin_bit = w_pin_rd;
        w_act_we  = 1'b0;
        w_act     = w_act_rd;
        w_dl_we   = 1'b0;
        w_dl      = w_sum;
        w_dl2_we  = 1'b0;
        w_notify  = 1'b0;

        unique case (r_state)
            topc_pkg::ST_IDLE: begin
                if (s_axis_tvalid) begin
                    if (w_mode == topc_pkg::MODE_TICK) begin
                        n_state = topc_pkg::ST_TICK;
                    end else if (!s_axis_tdata[3] && w_ch_ok) begin
                        n_state = topc_pkg::ST_CMD;
                    end else begin
                        n_state = topc_pkg::ST_OUT;
                    end
                end
            end
            topc_pkg::ST_TICK: begin
                n_state = topc_pkg::ST_SWEEP;
            end
            topc_pkg::ST_SWEEP: begin
                w_alu_req = '{a: w_dl_rd, b: r_time, sub: 1'b1};
                w_dl      = w_dl2_rd;
                if (w_act_rd != topc_pkg::ACT_IDLE && w_passed) begin
                    w_act_we = 1'b1;
                    w_act    = topc_pkg::ACT_IDLE;
                    unique case (w_act_rd)
                        topc_pkg::ACT_PULSE, topc_pkg::ACT_DTOGGLE: begin
                            w_pin_we  = 1'b1;
                            w_pin_bit = ~w_pin_rd;
                            w_notify  = 1'b1;
                        end
                        topc_pkg::ACT_DSET: begin
                            w_pin_we  = 1'b1;
                            w_pin_bit = 1'b1;
                            w_notify  = ~w_pin_rd;
                        end
                        topc_pkg::ACT_DCLEAR: begin
                            w_pin_we  = 1'b1;
                            w_pin_bit = 1'b0;
                            w_notify  = w_pin_rd;
                        end
                        topc_pkg::ACT_DPULSE: begin
                            w_pin_we  = 1'b1;
                            w_pin_bit = ~w_pin_rd;
                            w_notify  = 1'b1;
                            w_dl_we   = 1'b1;
                            w_act     = topc_pkg::ACT_PULSE;
                        end
                        default: begin
                            w_act = topc_pkg::ACT_IDLE;
                        end
                    endcase
                end
                if (w_last) begin
                    n_state = topc_pkg::ST_OUT;
                end
            end
            topc_pkg::ST_CMD: begin
                n_state  = topc_pkg::ST_OUT;
                w_act_we = 1'b1;
                if (r_mode == topc_pkg::MODE_PULSE) begin
                    w_alu_req = '{a: r_time, b: {1'b0, r_wid}, sub: 1'b0};
                end else begin
                    w_alu_req = '{a: r_time, b: {1'b0, r_dly}, sub: 1'b0};
                end
                unique case (r_mode)
                    topc_pkg::MODE_SET: begin
                        w_pin_we  = 1'b1;
                        w_pin_bit = 1'b1;
                        w_notify  = ~w_pin_rd;
                        w_act     = topc_pkg::ACT_IDLE;
                    end
                    topc_pkg::MODE_CLEAR: begin
                        w_pin_we  = 1'b1;
                        w_pin_bit = 1'b0;
                        w_notify  = w_pin_rd;
                        w_act     = topc_pkg::ACT_IDLE;
                    end
                    topc_pkg::MODE_TOGGLE: begin
                        w_pin_we  = 1'b1;
                        w_pin_bit = ~w_pin_rd;
                        w_notify  = 1'b1;
                        w_act     = topc_pkg::ACT_IDLE;
                    end
                    topc_pkg::MODE_PULSE: begin
                        if (w_act_rd == topc_pkg::ACT_IDLE) begin
                            w_pin_we  = 1'b1;
                            w_pin_bit = ~w_pin_rd;
                            w_notify  = 1'b1;
                        end
                        w_act   = topc_pkg::ACT_PULSE;
                        w_dl_we = 1'b1;
                    end
                    topc_pkg::MODE_DSET: begin
                        w_act   = topc_pkg::ACT_DSET;
                        w_dl_we = 1'b1;
                    end
                    topc_pkg::MODE_DCLEAR: begin
                        w_act   = topc_pkg::ACT_DCLEAR;
                        w_dl_we = 1'b1;
                    end
                    topc_pkg::MODE_DTOGGLE: begin
                        w_act   = topc_pkg::ACT_DTOGGLE;
                        w_dl_we = 1'b1;
                    end
                    topc_pkg::MODE_DPULSE: begin
                        w_act   = topc_pkg::ACT_DPULSE;
                        w_dl_we = 1'b1;
                        n_state = topc_pkg::ST_CMD2;
                    end
                    default: begin
                        w_act_we = 1'b0;
                    end
                endcase
            end
            topc_pkg::ST_CMD2: begin
                // second deadline follows the first by the pulse width
                w_alu_req = '{a: w_dl_rd, b: {1'b0, r_wid}, sub: 1'b0};
                w_dl2_we  = 1'b1;
                n_state   = topc_pkg::ST_OUT;
            end
            topc_pkg::ST_OUT: begin
                if (m_axis_tready) begin
                    n_state = topc_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = topc_pkg::ST_IDLE;
            end
        endcase
    end

    // command capture and index
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_mode <= w_mode;
            r_wid  <= w_wid_c;
            r_dly  <= (w_mode == topc_pkg::MODE_DPULSE) ? w_dly_c : w_dly;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= '0;
        end else if (w_accept) begin
            r_idx <= (w_mode == topc_pkg::MODE_TICK) ? '0 : IW'(w_ch);
        end else if (r_state == topc_pkg::ST_SWEEP && !w_last) begin
            r_idx <= r_idx + 1'b1;
        end
    end

    // channel state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_time <= '0;
            r_pin  <= '0;
            r_mask <= '0;
            for (int i = 0; i < NUM_OUTPUTS; i++) begin
                r_act[i] <= topc_pkg::ACT_IDLE;
            end
        end else begin
            if (w_accept) begin
                r_mask <= '0;
            end else if (w_notify) begin
                r_mask[r_idx] <= 1'b1;
            end
            if (r_state == topc_pkg::ST_TICK) begin
                r_time <= w_sum;
            end
            if (w_pin_we) begin
                r_pin[r_idx] <= w_pin_bit;
            end
            if (w_act_we) begin
                r_act[r_idx] <= w_act;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_dl_we) begin
            r_dl[r_idx] <= w_dl;
        end
        if (w_dl2_we) begin
            r_dl2[r_idx] <= w_sum;
        end
    end

    // result word
    assign w_pin_ext     = 32'(r_pin);
    assign w_mask_ext    = 32'(r_mask);
    assign m_axis_tvalid = (r_state == topc_pkg::ST_OUT);
    assign m_axis_tdata  = {w_mask_ext[7:0], w_pin_ext[7:0]};

endmodule
